FILE: rtl/core/pgs_pkg.sv
// Package: shared constants, types and helpers for the path gradient smoother.
package pgs_pkg;
  localparam int MaxPoints = 64;
  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);

  localparam logic [1:0] RegDataWeight = 2'd0;
  localparam logic [1:0] RegTolerance  = 2'd1;
  localparam logic [1:0] RegMaxSweeps  = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StRdA, StRdB, StMul, StSum, StWr, StCheck, StOutRd, StOutWait, StOut
  } state_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic             load;      // store input point
    logic [AddrW-1:0] load_addr;
    logic             rd;        // issue read of orig[i], smooth[i], orig[i+1]
    logic [AddrW-1:0] rd_addr;
    logic             lat_prev;  // take smooth[i-1] from the smoothed memory
    logic             mul;       // register products
    logic             sum;       // form rounded new value
    logic             wr;        // write smooth[i], accumulate change
    logic             clr_sum;
    logic             ord;       // output read
    logic             emit;
  } pgs_cmd_t;

  typedef struct packed {
    logic below_tol;
  } pgs_sts_t;
endpackage

FILE: rtl/core/pgs_datapath.sv
// Datapath: point memories, weighted update arithmetic and change sum.
module pgs_datapath (
  input  logic                  clk_i,
  input  pgs_pkg::pgs_cmd_t     cmd_i,
  input  logic [16:0]           data_weight_i,
  input  logic [30:0]           tolerance_i,
  input  logic signed [31:0]    x_i,
  input  logic signed [31:0]    y_i,
  output pgs_pkg::pgs_sts_t     sts_o,
  output logic signed [31:0]    out_x_o,
  output logic signed [31:0]    out_y_o
);
  import pgs_pkg::*;

  logic [63:0] orig_mem [MaxPoints];
  logic [63:0] orig2_mem [MaxPoints];
  logic [63:0] smo_mem [MaxPoints];
  logic [63:0] orig_q, orign_q, smo_q, prev_q;
  logic [AddrW-1:0] wa_q;
  logic signed [32:0] dx_q [2], sx_q [2];
  logic signed [31:0] cur_q [2];
  logic signed [51:0] pd_q [2], ps_q [2];
  logic signed [31:0] nv_q [2];
  logic [32:0] ad_q [2];
  logic [39:0] chg_q;
  logic signed [31:0] nv_d [2];
  logic signed [33:0] sm_d [2];
  logic [16:0] w, s;

  assign w = (data_weight_i > 17'd65536) ? 17'd65536 : data_weight_i;
  assign s = 17'd65536 - w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      orig_mem[cmd_i.load_addr]  <= {x_i, y_i};
      orig2_mem[cmd_i.load_addr] <= {x_i, y_i};
      smo_mem[cmd_i.load_addr]   <= {x_i, y_i};
    end else if (cmd_i.wr) begin
      smo_mem[wa_q] <= {nv_q[0], nv_q[1]};
    end
    if (cmd_i.rd) begin
      orig_q  <= orig_mem[cmd_i.rd_addr];
      orign_q <= orig2_mem[cmd_i.rd_addr + AddrW'(1)];
      wa_q    <= cmd_i.rd_addr;
    end
    if (cmd_i.rd || cmd_i.ord) smo_q <= smo_mem[cmd_i.rd_addr];
    if (cmd_i.lat_prev) prev_q <= smo_mem[cmd_i.rd_addr - AddrW'(1)];
    if (cmd_i.wr) prev_q <= {nv_q[0], nv_q[1]};
  end

  // Stage products: data part and smoothing part per coordinate.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      sm_d[j] = 34'(signed'(prev_q[63-32*j -: 32])) + 34'(signed'(orign_q[63-32*j -: 32]))
              - 34'(signed'(smo_q[63-32*j -: 32])) - 34'(signed'(smo_q[63-32*j -: 32]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 2; j++) begin
      if (cmd_i.mul) begin
        cur_q[j] <= signed'(smo_q[63-32*j -: 32]);
        pd_q[j] <= 52'(signed'({1'b0, w}) * (34'(signed'(orig_q[63-32*j -: 32]))
                                  - 34'(signed'(smo_q[63-32*j -: 32]))));
        ps_q[j] <= 52'(signed'({1'b0, s}) * sm_d[j]);
      end
    end
  end

  always_comb begin
    logic signed [52:0] t;
    logic signed [36:0] r;
    logic signed [37:0] n;
    for (int j = 0; j < 2; j++) begin
      t = 53'(pd_q[j]) + 53'(ps_q[j]) + 53'sd32768;
      r = 37'(t >>> 16);
      n = 38'(cur_q[j]) + 38'(r);
      if (n > 38'sd2147483647) nv_d[j] = 32'sh7fffffff;
      else if (n < -38'sd2147483648) nv_d[j] = 32'sh80000000;
      else nv_d[j] = 32'(n);
    end
  end

  always_ff @(posedge clk_i) begin
    logic [40:0] acc;
    if (cmd_i.sum) begin
      for (int j = 0; j < 2; j++) begin
        nv_q[j] <= nv_d[j];
        ad_q[j] <= (nv_d[j] >= cur_q[j]) ? 33'(33'(nv_d[j]) - 33'(cur_q[j]))
                                         : 33'(33'(cur_q[j]) - 33'(nv_d[j]));
      end
    end
    if (cmd_i.clr_sum) chg_q <= '0;
    else if (cmd_i.wr) begin
      acc = 41'(chg_q) + 41'(ad_q[0]) + 41'(ad_q[1]);
      chg_q <= acc[40] ? '1 : acc[39:0];
    end
  end

  assign sts_o.below_tol = chg_q < 40'(tolerance_i);
  assign out_x_o = signed'(smo_q[63:32]);
  assign out_y_o = signed'(smo_q[31:0]);
endmodule

FILE: rtl/core/pgs_ctrl.sv
// Controller: load, sweep sequencing, convergence check and emission.
module pgs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_i,
  input  logic [15:0]       max_sweeps_i,
  input  pgs_pkg::pgs_sts_t sts_i,
  output pgs_pkg::pgs_cmd_t cmd_o,
  output logic              busy_o,
  output logic              strobe_o,
  output logic              out_last_o,
  output logic              limit_o
);
  import pgs_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [15:0] sw_q, sw_d;
  logic lim_q, lim_d;
  logic acc;
  logic [CntW-1:0] total;

  assign acc = start_i && !busy_o;
  assign total = (cnt_q < CntW'(MaxPoints)) ? cnt_q + CntW'(1) : cnt_q;
  logic has_int;
  assign has_int = cnt_q > CntW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; idx_q <= '0; sw_q <= '0; lim_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; idx_q <= idx_d; sw_q <= sw_d; lim_q <= lim_d;
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; sw_d = sw_q; lim_d = lim_q;
    unique case (state_q)
      StIdle: if (acc) begin
        cnt_d = total;
        if (last_i) begin
          sw_d = '0; idx_d = AddrW'(1);
          if (max_sweeps_i == '0) begin
            lim_d = 1'b1; idx_d = '0; state_d = StOutRd;
          end else state_d = StRdA;
        end
      end
      StRdA: state_d = has_int ? StRdB : StCheck;
      StRdB: state_d = StMul;
      StMul: state_d = StSum;
      StSum: state_d = StWr;
      StWr: begin
        if (CntW'(idx_q) + CntW'(2) < cnt_q) begin
          idx_d = idx_q + AddrW'(1); state_d = StRdB;
        end else state_d = StCheck;
      end
      StCheck: begin
        sw_d = sw_q + 16'd1; idx_d = AddrW'(1);
        if (sts_i.below_tol) begin
          lim_d = 1'b0; idx_d = '0; state_d = StOutRd;
        end else if (sw_q + 16'd1 >= max_sweeps_i) begin
          lim_d = 1'b1; idx_d = '0; state_d = StOutRd;
        end else state_d = StRdA;
      end
      StOutRd: state_d = StOut;
      StOut: begin
        if (CntW'(idx_q) + CntW'(1) >= cnt_q) begin
          cnt_d = '0; state_d = StIdle;
        end else begin
          idx_d = idx_q + AddrW'(1); state_d = StOut;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load = acc && (cnt_q < CntW'(MaxPoints) || last_i);
    cmd_o.load_addr = (cnt_q < CntW'(MaxPoints)) ? AddrW'(cnt_q) : AddrW'(MaxPoints - 1);
    cmd_o.rd_addr = idx_q;
    unique case (state_q)
      StRdA:   begin cmd_o.clr_sum = 1'b1; cmd_o.lat_prev = 1'b1; end
      StRdB:   cmd_o.rd = 1'b1;
      StMul:   cmd_o.mul = 1'b1;
      StSum:   cmd_o.sum = 1'b1;
      StWr:    cmd_o.wr = 1'b1;
      StOutRd: cmd_o.ord = 1'b1;
      StOut:   begin cmd_o.ord = 1'b1; cmd_o.rd_addr = idx_q + AddrW'(1); end
      default: ;
    endcase
  end

  assign busy_o = state_q != StIdle;
  assign strobe_o = state_q == StOut;
  assign out_last_o = strobe_o && (CntW'(idx_q) + CntW'(1) >= cnt_q);
  assign limit_o = lim_q;

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy_o) else $error("strobe outside busy");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_last_o |=> state_q == StIdle) else $error("last not final");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StIdle) else $error("load while busy");
endmodule

FILE: rtl/core/path_gradient_smoother.sv
// Top level: configuration registers and controller/datapath wiring.
// Usage: send points with start_i while busy_o is low, one per cycle, with
// last_point_i on the final one. Extra points beyond 64 are dropped; a final
// point arriving when full replaces the last entry. After the final point
// busy_o rises and the block sweeps the interior points, unless max_sweeps
// is zero. Each interior point passes through read, multiply, round and write
// steps per sweep in one shared update unit, and each sweep adds a clear and
// a check step. Results then follow one per cycle, N results in all, marked
// by strobe_o; the receiver cannot stall, so each transaction on the result
// ports lasts exactly one cycle. busy_o drops after the last result, so a new
// path can start on the next cycle. out_last_o marks the final point and
// sweep_limit_hit_o is set on every result when max_sweeps ran out.
// Configuration writes go through cfg_valid_i/cfg_ready_o; cfg_ready_o is
// low while busy. Reset restores register defaults and the point count;
// memory contents are undefined until loaded.
module path_gradient_smoother (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic               last_point_i,
  output logic               strobe_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               out_last_o,
  output logic               sweep_limit_hit_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import pgs_pkg::*;

  logic [16:0] dw_q;
  logic [30:0] tol_q;
  logic [15:0] ms_q;
  pgs_cmd_t cmd;
  pgs_sts_t sts;
  logic lim;

  // Registers only change while the block is idle (busy_o low).
  assign cfg_ready_o = !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q <= 17'd32768; tol_q <= 31'd66; ms_q <= 16'd1000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegDataWeight: dw_q  <= cfg_data_i[16:0];
        RegTolerance:  tol_q <= cfg_data_i[30:0];
        RegMaxSweeps:  ms_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  pgs_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .last_i(last_point_i), .max_sweeps_i(ms_q),
    .sts_i(sts), .cmd_o(cmd), .busy_o, .strobe_o, .out_last_o, .limit_o(lim)
  );

  pgs_datapath u_dp (
    .clk_i, .cmd_i(cmd), .data_weight_i(dw_q), .tolerance_i(tol_q),
    .x_i(x_coord_i), .y_i(y_coord_i), .sts_o(sts), .out_x_o, .out_y_o
  );

  assign sweep_limit_hit_o = lim;
endmodule
